/* rtl/core/ssb_pkg.sv */
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared types and codes for the sorted set builder: payload structs,
// operation and status codes, controller states and cell control.
// ----------------------------------------------------------------------------
package ssb_pkg;

  // Field widths fixed by the item format.
  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNION = 2'd1;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [VALUE_W-1:0]  value_out;
    logic                last;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_BUILD
  } state_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_COMPARE,
    CM_INSERT,
    CM_ROTATE
  } cell_mode_t;

  // Control broadcast from the controller to the row of cells.
  typedef struct packed {
    cell_mode_t         mode;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

/* rtl/core/ssb_cell.sv */
// ----------------------------------------------------------------------------
// ssb_cell
// One entry of the sorted row. It compares its entry with the broadcast
// value, shifts right from its left neighbor on insert, and takes its right
// neighbor (or the head entry at the tail) while the row rotates for output.
// ----------------------------------------------------------------------------
module ssb_cell (
  input  logic                            clk,
  input  ssb_pkg::cell_ctrl_t             ctrl,
  input  logic                            occ,
  input  logic                            tail,
  input  logic [ssb_pkg::VALUE_W-1:0]     left_val,
  input  logic                            left_gt,
  input  logic [ssb_pkg::VALUE_W-1:0]     right_val,
  input  logic [ssb_pkg::VALUE_W-1:0]     head_val,
  output logic [ssb_pkg::VALUE_W-1:0]     val,
  output logic                            gt,
  output logic                            eq
);

  logic [ssb_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic                        gt_r, gt_nxt;
  logic                        eq_r, eq_nxt;

  // Next entry and compare flags for the current cell mode.
  always_comb begin
    val_nxt = val_r;
    gt_nxt  = gt_r;
    eq_nxt  = eq_r;
    case (ctrl.mode)
      ssb_pkg::CM_COMPARE: begin
        // An unoccupied cell counts as larger than any value.
        gt_nxt = !occ || (val_r > ctrl.value);
        eq_nxt = occ && (val_r == ctrl.value);
      end
      ssb_pkg::CM_INSERT: begin
        // The first larger cell takes the new value, the ones after it shift.
        if (gt_r) begin
          val_nxt = left_gt ? left_val : ctrl.value;
        end
      end
      ssb_pkg::CM_ROTATE: begin
        val_nxt = tail ? head_val : right_val;
      end
      default: begin
      end
    endcase
  end

  // Entry and flag registers; payload only, no reset.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    gt_r  <= gt_nxt;
    eq_r  <= eq_nxt;
  end

  assign val = val_r;
  assign gt  = gt_r;
  assign eq  = eq_r;

endmodule

/* rtl/core/sorted_set_builder.sv */
// ----------------------------------------------------------------------------
// sorted_set_builder
// Sorted store of up to DEPTH 32-bit type indices held in a row of cells.
// ----------------------------------------------------------------------------
// Usage: drive in_data and raise start; the transfer happens at a rising edge
// where start is high and busy is low. Results appear on out_data for exactly
// one cycle each, marked by out_valid; the receiver cannot stall them.
// An add or union item passes two states: S_CMP compares every entry with
// the value, S_INS inserts, shifting larger entries right, unless the store
// is full or a union value is present. Its single result shows in the cycle
// after S_INS, when busy is already low, so the next item can be taken then.
// A build of a non-empty store rotates the row one cell per cycle, emitting
// the head entry each cycle: count results, registered into out_data, come
// on consecutive cycles with last on the final one; after count
// rotations the row is back in its original order. A build of an empty
// store, or an unused operation code, answers in the next cycle with busy
// staying low.
// Reset clears the entry count and the controller; entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_set_builder #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ssb_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ssb_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  ssb_pkg::state_t                state_r, state_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               idx_r, idx_nxt;
  logic [ssb_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [ssb_pkg::VALUE_W-1:0]    value_r, value_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ssb_pkg::out_item_t             out_r, out_nxt;
  ssb_pkg::cell_ctrl_t            ctrl;

  logic [ssb_pkg::VALUE_W-1:0]    val_w [DEPTH];
  logic [DEPTH-1:0]               gt_w;
  logic [DEPTH-1:0]               eq_w;
  logic [DEPTH-1:0]               occ_w;
  logic [DEPTH-1:0]               tail_w;

  logic accept;
  logic full;
  logic present;
  logic do_insert;

  assign accept  = start && (state_r == ssb_pkg::S_IDLE);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign present = |eq_w;
  assign busy    = (state_r != ssb_pkg::S_IDLE);

  // Row of cells; occupancy and tail come from the entry count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ssb_pkg::VALUE_W-1:0] left_val;
    logic                        left_gt;
    logic [ssb_pkg::VALUE_W-1:0] right_val;

    assign occ_w[i]  = (count_r > CNT_W'(i));
    assign tail_w[i] = (count_r == CNT_W'(i + 1));

    if (i == 0) begin : g_first
      assign left_val = val_w[0];
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = val_w[i-1];
      assign left_gt  = gt_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = val_w[0];
    end else begin : g_mid
      assign right_val = val_w[i+1];
    end

    ssb_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ_w[i]),
      .tail      (tail_w[i]),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .head_val  (val_w[0]),
      .val       (val_w[i]),
      .gt        (gt_w[i]),
      .eq        (eq_w[i])
    );
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssb_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    op_r    <= op_nxt;
    value_r <= value_nxt;
    out_r   <= out_nxt;
  end

  // Next state, cell control and result formation.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctrl.mode     = ssb_pkg::CM_HOLD;
    ctrl.value    = value_r;
    do_insert     = 1'b0;
    case (state_r)
      ssb_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt    = in_data.op;
          value_nxt = in_data.value;
          idx_nxt   = '0;
          if (in_data.op == ssb_pkg::OP_ADD || in_data.op == ssb_pkg::OP_UNION) begin
            state_nxt = ssb_pkg::S_CMP;
          end else if (in_data.op == ssb_pkg::OP_BUILD && count_r != '0) begin
            state_nxt = ssb_pkg::S_BUILD;
          end else begin
            // Empty build or unused code: answer at once.
            out_valid_nxt     = 1'b1;
            out_nxt.value_out = '0;
            out_nxt.last      = 1'b1;
            out_nxt.status    = (in_data.op == ssb_pkg::OP_BUILD) ?
                                ssb_pkg::ST_EMPTY : ssb_pkg::ST_OK;
          end
        end
      end
      ssb_pkg::S_CMP: begin
        ctrl.mode = ssb_pkg::CM_COMPARE;
        state_nxt = ssb_pkg::S_INS;
      end
      ssb_pkg::S_INS: begin
        // A present value is reported before the full test on union.
        out_nxt.value_out = '0;
        out_nxt.last      = 1'b1;
        if (op_r == ssb_pkg::OP_UNION && present) begin
          out_nxt.status = ssb_pkg::ST_PRESENT;
        end else if (full) begin
          out_nxt.status = ssb_pkg::ST_FULL;
        end else begin
          out_nxt.status = ssb_pkg::ST_OK;
          do_insert      = 1'b1;
        end
        if (do_insert) begin
          ctrl.mode = ssb_pkg::CM_INSERT;
          count_nxt = count_r + 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ssb_pkg::S_IDLE;
      end
      ssb_pkg::S_BUILD: begin
        // Emit the head entry and rotate the occupied part of the row.
        ctrl.mode         = ssb_pkg::CM_ROTATE;
        out_valid_nxt     = 1'b1;
        out_nxt.value_out = val_w[0];
        out_nxt.status    = ssb_pkg::ST_OK;
        out_nxt.last      = (idx_r == count_r - 1'b1);
        idx_nxt           = idx_r + 1'b1;
        if (out_nxt.last) begin
          state_nxt = ssb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ssb_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/core/ssb_checker.sv */
// ----------------------------------------------------------------------------
// ssb_checker
// Port-level checks for the sorted set builder, bound to the top level.
// ----------------------------------------------------------------------------
module ssb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ssb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input ssb_pkg::out_item_t out_data
);

  // Reset leaves the block idle with no result on the ports.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // An add transfer always occupies the row in the next cycle.
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.op == ssb_pkg::OP_ADD) |=> busy)
    else $error("add transfer did not make the block busy");

  // Any status other than ok ends the results of its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ssb_pkg::ST_OK) |-> out_data.last)
    else $error("non-ok status without last");

  // Any result with a status other than ok shows zero as its value.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ssb_pkg::ST_OK) |-> (out_data.value_out == '0))
    else $error("non-ok result with nonzero value");

  // A result that is not the last is followed by another in the next cycle.
  a_build_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> out_valid)
    else $error("gap in build result stream");

endmodule

bind sorted_set_builder ssb_checker u_ssb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
